@@ design/gfc_pkg.sv @@
// ----------------------------------------------------------------------------
// gfc_pkg
// Types and constants shared by the gated frequency capture core.
// ----------------------------------------------------------------------------
package gfc_pkg;

  localparam int NUM_CHANNELS_DEF = 6;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  // register indexes, taken from paddr[3:2]
  localparam logic [1:0] REG_ZERO_TIME     = 2'd0;
  localparam logic [1:0] REG_SAMPLE_TIME   = 2'd1;
  localparam logic [1:0] REG_DEBOUNCE_TIME = 2'd2;

  localparam logic [31:0] ZERO_TIME_RST     = 32'd1000000;
  localparam logic [31:0] SAMPLE_TIME_RST   = 32'd250000;
  localparam logic [31:0] DEBOUNCE_TIME_RST = 32'd50;

  localparam logic CMD_OVERFLOW = 1'b0;
  localparam logic CMD_CAPTURE  = 1'b1;

  localparam logic [15:0] LATE_CAPTURE_MID = 16'h8000;
  localparam logic [31:0] COUNTER_SPAN     = 32'h0001_0000;

  typedef enum logic [1:0] {
    PH_IGNORE  = 2'd0,
    PH_CAPTURE = 2'd1,
    PH_SAMPLE  = 2'd2
  } phase_e;

  typedef struct packed {
    logic        cmd;
    logic [2:0]  channel;
    logic [15:0] counter_low;
    logic        capture_pending;
    logic        lock_freq;
    logic        lock_count;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  channel_out;
    logic [31:0] period_time;
    logic [15:0] edge_count;
    logic        new_period;
    logic [31:0] pulse_total;
  } out_beat_t;

  typedef struct packed {
    logic [31:0] zero_time;
    logic [31:0] sample_time;
    logic [31:0] debounce_time;
  } cfg_t;

  typedef struct packed {
    logic [15:0] overflow_count;
    logic [31:0] window_start;
    logic [31:0] last_edge;
    logic [15:0] running_edges;
    logic [15:0] latched_edges;
    logic [31:0] latched_time;
    logic [31:0] pulse_sum;
    logic [31:0] pulse_holdover;
    phase_e      phase;
    logic        overflow_before_capture;
  } chan_state_t;

endpackage

@@ design/gated_frequency_capture_core.sv @@
// ----------------------------------------------------------------------------
// gated_frequency_capture_core
// Per-channel reciprocal frequency meter with pulse totals.
// ----------------------------------------------------------------------------
// Takes one beat per cycle while the output is not stalled, each an overflow
// tick or a capture edge for one channel, and presents one result beat for
// it from the output register once the beat has left the s1 stage. Channel
// state sits in a RAM with a registered read; the update is read, modify,
// write back, with the just-written entry forwarded when the next beat hits
// the same channel. The result register decouples the output, so one new
// beat can still be taken while a result waits. Channel state comes up zeroed
// after reset through per-entry valid bits, so no clearing pass is needed.
// Registers sit at 0x0 zero_time, 0x4 sample_time, 0x8 debounce_time.
module gated_frequency_capture_core #(
  parameter int NUM_CHANNELS = gfc_pkg::NUM_CHANNELS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  gfc_pkg::in_beat_t                 in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output gfc_pkg::out_beat_t                out_data_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [gfc_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [gfc_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [gfc_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import gfc_pkg::*;

  localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // configuration registers
  cfg_t       cfg_q, cfg_d;
  logic [1:0] reg_idx;
  logic       cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    prdata = '0;
    unique case (reg_idx)
      REG_ZERO_TIME: begin
        prdata = cfg_q.zero_time;
        if (cfg_wr) cfg_d.zero_time = pwdata;
      end
      REG_SAMPLE_TIME: begin
        prdata = cfg_q.sample_time;
        if (cfg_wr) cfg_d.sample_time = pwdata;
      end
      REG_DEBOUNCE_TIME: begin
        prdata = cfg_q.debounce_time;
        if (cfg_wr) cfg_d.debounce_time = pwdata;
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.zero_time     <= ZERO_TIME_RST;
      cfg_q.sample_time   <= SAMPLE_TIME_RST;
      cfg_q.debounce_time <= DEBOUNCE_TIME_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // pipeline control
  logic        s1_valid_q;
  in_beat_t    s1_beat_q;
  logic [AW-1:0] s1_addr_q;
  logic        s1_in_range_q;
  logic        s1_fwd_q;
  logic        s1_entry_valid_q;
  chan_state_t fwd_data_q;

  logic        out_valid_q;
  out_beat_t   out_data_q;

  logic [NUM_CHANNELS-1:0] valid_q;

  logic          accept;
  logic          advance;
  logic [AW-1:0] rd_addr;
  logic          rd_in_range;
  logic          ram_we;

  chan_state_t ram_rdata;
  chan_state_t cur_state;
  chan_state_t nxt_state;
  logic        latched;

  assign advance     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || advance;
  assign accept      = in_valid_i && in_ready_o;
  assign rd_addr     = AW'(in_data_i.channel);
  assign rd_in_range = 32'(in_data_i.channel) < NUM_CHANNELS;
  assign ram_we      = advance && s1_in_range_q;

  gfc_ram #(
    .WIDTH ($bits(chan_state_t)),
    .DEPTH (NUM_CHANNELS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_addr_q),
    .wdata_i (nxt_state),
    .re_i    (accept),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    if (s1_fwd_q) begin
      cur_state = fwd_data_q;
    end else if (s1_entry_valid_q) begin
      cur_state = ram_rdata;
    end else begin
      cur_state = '0;
    end
  end

  gfc_chan_update u_update (
    .cfg_i     (cfg_q),
    .beat_i    (s1_beat_q),
    .cur_i     (cur_state),
    .nxt_o     (nxt_state),
    .latched_o (latched)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q       <= 1'b0;
      s1_fwd_q         <= 1'b0;
      s1_entry_valid_q <= 1'b0;
      out_valid_q      <= 1'b0;
      valid_q          <= '0;
    end else begin
      if (accept) begin
        s1_valid_q       <= 1'b1;
        s1_fwd_q         <= ram_we && (s1_addr_q == rd_addr);
        s1_entry_valid_q <= rd_in_range && valid_q[rd_addr];
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (ram_we) begin
        valid_q[s1_addr_q] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_beat_q     <= in_data_i;
      s1_addr_q     <= rd_addr;
      s1_in_range_q <= rd_in_range;
      fwd_data_q    <= nxt_state;
    end
    if (advance) begin
      out_data_q.channel_out <= s1_beat_q.channel;
      if (s1_in_range_q) begin
        out_data_q.period_time <= nxt_state.latched_time;
        out_data_q.edge_count  <= nxt_state.latched_edges;
        out_data_q.new_period  <= latched;
        out_data_q.pulse_total <= nxt_state.pulse_sum;
      end else begin
        out_data_q.period_time <= '0;
        out_data_q.edge_count  <= '0;
        out_data_q.new_period  <= 1'b0;
        out_data_q.pulse_total <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // checks
  a_new_period_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.new_period |-> 32'(out_data_o.channel_out) < NUM_CHANNELS)
    else $error("new period on a channel out of range");

  a_out_of_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !(32'(out_data_o.channel_out) < NUM_CHANNELS) |->
      out_data_o.period_time == '0 && out_data_o.pulse_total == '0)
    else $error("out-of-range beat carries channel data");

  a_entry_marked_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> valid_q[$past(s1_addr_q)])
    else $error("written entry not marked valid");

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !advance |=> s1_valid_q && $stable(s1_beat_q))
    else $error("stalled stage lost its beat");

endmodule

@@ design/gfc_ram.sv @@
// ----------------------------------------------------------------------------
// gfc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gfc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/gfc_chan_update.sv @@
// ----------------------------------------------------------------------------
// gfc_chan_update
// Next state of one channel for an overflow tick or a capture edge.
// ----------------------------------------------------------------------------
module gfc_chan_update (
  input  gfc_pkg::cfg_t        cfg_i,
  input  gfc_pkg::in_beat_t    beat_i,
  input  gfc_pkg::chan_state_t cur_i,
  output gfc_pkg::chan_state_t nxt_o,
  output logic                 latched_o
);
  import gfc_pkg::*;

  always_comb begin
    chan_state_t s;
    logic [15:0] oc_inc;
    logic [31:0] now;
    logic [31:0] elapsed;
    logic [31:0] since_last;
    logic        lat;
    s = cur_i;
    lat = 1'b0;
    oc_inc = cur_i.overflow_count + 16'd1;
    now = '0;
    elapsed = '0;
    since_last = '0;
    if (beat_i.cmd == CMD_OVERFLOW) begin
      s.overflow_count = oc_inc;
      now = {oc_inc, beat_i.counter_low};
      elapsed = now - cur_i.window_start;
      if (elapsed >= cfg_i.zero_time) begin
        if (!beat_i.lock_freq) begin
          s.latched_time  = elapsed;
          s.latched_edges = cur_i.running_edges;
          s.running_edges = '0;
          s.window_start  = now;
          s.phase         = PH_IGNORE;
          lat = 1'b1;
        end
      end else if (elapsed >= cfg_i.sample_time) begin
        if (cur_i.running_edges != '0 && cur_i.phase == PH_CAPTURE) begin
          s.phase = PH_SAMPLE;
        end
      end
      s.overflow_before_capture = beat_i.capture_pending;
    end else begin
      now = {cur_i.overflow_count, beat_i.counter_low};
      if (cur_i.overflow_before_capture && beat_i.counter_low > LATE_CAPTURE_MID) begin
        now = now - COUNTER_SPAN;
      end
      since_last = now - cur_i.last_edge;
      if (since_last > cfg_i.debounce_time) begin
        if (cur_i.phase == PH_IGNORE) begin
          s.phase = PH_CAPTURE;
          s.window_start = now;
        end else begin
          s.running_edges = cur_i.running_edges + 16'd1;
          if (cur_i.phase == PH_SAMPLE && !beat_i.lock_freq) begin
            s.phase         = PH_CAPTURE;
            s.latched_time  = now - cur_i.window_start;
            s.window_start  = now;
            s.latched_edges = cur_i.running_edges + 16'd1;
            s.running_edges = '0;
            lat = 1'b1;
          end
        end
        if (!beat_i.lock_count) begin
          s.pulse_sum      = cur_i.pulse_sum + 32'd1 + cur_i.pulse_holdover;
          s.pulse_holdover = '0;
        end else begin
          s.pulse_holdover = cur_i.pulse_holdover + 32'd1;
        end
      end
      s.last_edge = now;
      s.overflow_before_capture = 1'b0;
    end
    nxt_o = s;
    latched_o = lat;
  end

endmodule
